### rtl/sha1_message_digest_core_defines.svh
// Assertion macros used by the SHA-1 core RTL.
`ifndef SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH

// Clocked property, masked while reset is asserted.
`define SHA1_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define SHA1_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### rtl/sha1_pkg.sv
// Types and constants for the SHA-1 core.
`timescale 1ns / 1ps
package sha1_pkg;

  // Initial hash words, H4 in the top slot down to H0 in the bottom slot
  localparam logic [4:0][31:0] SHA1_IV = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [6:0] ROUND_R1   = 7'd20;
  localparam logic [6:0] ROUND_R2   = 7'd40;
  localparam logic [6:0] ROUND_R3   = 7'd60;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LENGTH_AT   = 6'd56;
  localparam logic [5:0] BYTE_LAST   = 6'd63;
  localparam logic [2:0] DIGEST_LAST = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_OUT
  } sha1_state_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1_work_t;

endpackage

### rtl/sha1_round.sv
// One SHA-1 round: round function, constant select and the five-way add.
`timescale 1ns / 1ps
module sha1_round import sha1_pkg::*; (
  input  sha1_work_t  work_i,
  input  logic [31:0] w_i,
  input  logic [6:0]  round_i,
  output sha1_work_t  work_o
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    if (round_i < ROUND_R1) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = K_R0;
    end else if (round_i < ROUND_R2) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K_R1;
    end else if (round_i < ROUND_R3) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = K_R2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K_R3;
    end
  end

  assign t = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + w_i;

  assign work_o.a = t;
  assign work_o.b = work_i.a;
  assign work_o.c = {work_i.b[1:0], work_i.b[31:2]};
  assign work_o.d = work_i.c;
  assign work_o.e = work_i.d;

endmodule

### rtl/sha1_message_digest_core.sv
// SHA-1 core: byte packing, padding, round sequencer and digest output.
//
//  channel | direction | payload                           | handshake
//  --------+-----------+-----------------------------------+--------------------------
//  in      | to core   | cmd_i, data_byte_i                | in_valid_i / in_ready_o
//  out     | from core | digest_word_o, word_index_o, last_o | out_valid_o / out_ready_i
//
// An append beat is taken while idle; the 64th byte of a block also starts the rounds
// and the feed-forward, run one after another on the single shared round unit.
// A finish beat pads and compresses the block, and a second block when the length
// spills into it, then gives five output beats, each taken when out_ready_i is high.
// in_ready_o is low from a block fill until compression ends, and while the
// digest is being delivered; a stalled output beat holds its word.
// Reset restores the initial hash words and clears length and byte count.
`timescale 1ns / 1ps
`include "sha1_message_digest_core_defines.svh"
module sha1_message_digest_core import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_o
);

  sha1_state_e      state_q, state_d;
  logic [6:0]       round_q, round_d;
  logic [2:0]       idx_q, idx_d;
  logic             fin_q, fin_d;
  logic             two_q, two_d;
  logic [5:0]       pos_q, pos_d;
  logic [63:0]      len_q, len_d;
  logic [4:0][31:0] hash_q, hash_d;
  sha1_work_t       work_q, work_d;
  logic [31:0]      sched_q [16];
  logic [31:0]      sched_d [16];

  sha1_work_t       round_work;
  sha1_work_t       hash_work;
  sha1_work_t       sum_work;
  logic [4:0][31:0] sum_words;
  logic [31:0]      sched_mix;

  sha1_round u_round (
    .work_i  (work_q),
    .w_i     (sched_q[0]),
    .round_i (round_q),
    .work_o  (round_work)
  );

  assign hash_work = '{a: hash_q[0], b: hash_q[1], c: hash_q[2], d: hash_q[3], e: hash_q[4]};

  // feed-forward
  assign sum_words[0] = hash_q[0] + work_q.a;
  assign sum_words[1] = hash_q[1] + work_q.b;
  assign sum_words[2] = hash_q[2] + work_q.c;
  assign sum_words[3] = hash_q[3] + work_q.d;
  assign sum_words[4] = hash_q[4] + work_q.e;
  assign sum_work = '{a: sum_words[0], b: sum_words[1], c: sum_words[2],
                      d: sum_words[3], e: sum_words[4]};

  // schedule word W[t+16], from fixed taps of the shift line
  assign sched_mix = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = hash_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_o        = (idx_q == DIGEST_LAST);

  always_comb begin
    logic [5:0] bpos;
    state_d = state_q;
    round_d = round_q;
    idx_d   = idx_q;
    fin_d   = fin_q;
    two_d   = two_q;
    pos_d   = pos_q;
    len_d   = len_q;
    hash_d  = hash_q;
    work_d  = work_q;
    sched_d = sched_q;
    bpos    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          for (int w = 0; w < 16; w++) begin
            for (int l = 0; l < 4; l++) begin
              bpos = {4'(w), 2'(l)};
              if (!cmd_i) begin
                if (bpos == pos_q) sched_d[w][8*(3-l) +: 8] = data_byte_i;
              end else begin
                if (bpos == pos_q) sched_d[w][8*(3-l) +: 8] = PAD_BYTE;
                else if (bpos > pos_q) sched_d[w][8*(3-l) +: 8] = 8'h00;
              end
            end
          end
          if (!cmd_i) begin
            len_d = len_q + 64'd8;
            pos_d = pos_q + 6'd1;
            if (pos_q == BYTE_LAST) begin
              work_d  = hash_work;
              round_d = '0;
              state_d = ST_ROUND;
            end
          end else begin
            // length fits behind the pad byte in this block
            if (pos_q < LENGTH_AT) begin
              sched_d[14] = len_q[63:32];
              sched_d[15] = len_q[31:0];
            end
            two_d   = (pos_q >= LENGTH_AT);
            fin_d   = 1'b1;
            pos_d   = '0;
            work_d  = hash_work;
            round_d = '0;
            state_d = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) sched_d[i] = sched_q[i+1];
        sched_d[15] = {sched_mix[30:0], sched_mix[31]};
        work_d  = round_work;
        round_d = round_q + 7'd1;
        if (round_q == ROUND_LAST) state_d = ST_FEED;
      end
      ST_FEED: begin
        hash_d = sum_words;
        if (fin_q && two_q) begin
          // extra block: zeros and the bit count
          for (int i = 0; i < 14; i++) sched_d[i] = '0;
          sched_d[14] = len_q[63:32];
          sched_d[15] = len_q[31:0];
          work_d  = sum_work;
          two_d   = 1'b0;
          round_d = '0;
          state_d = ST_ROUND;
        end else if (fin_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (idx_q == DIGEST_LAST) begin
            hash_d  = SHA1_IV;
            len_d   = '0;
            fin_d   = 1'b0;
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
      two_q   <= 1'b0;
      pos_q   <= '0;
      len_q   <= '0;
      hash_q  <= SHA1_IV;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
      two_q   <= two_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      hash_q  <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    sched_q <= sched_d;
  end

  `SHA1_ASSERT_NEVER(a_ready_and_valid, in_ready_o && out_valid_o, "input taken during output")
  `SHA1_ASSERT_CLK(a_round_bound, (state_q == ST_ROUND) |-> (round_q <= ROUND_LAST), "round overrun")
  `SHA1_ASSERT_CLK(a_feed_after_last, (state_q == ST_ROUND && round_q == ROUND_LAST) |=> (state_q == ST_FEED), "no feed after last round")
  `SHA1_ASSERT_CLK(a_iv_after_digest, (out_valid_o && out_ready_i && last_o) |=> (hash_q == SHA1_IV && len_q == 64'd0), "state not restored after digest")

endmodule
